// ===== src/ppe_pkg.sv =====
// Shared types and constants of the piecewise polynomial evaluator.
// No dependencies; used by ppe_horner_step and piecewise_polynomial_eval.
package ppe_pkg;

    // Store sizes
    localparam int MAX_BREAKPOINTS = 8;
    localparam int MAX_TERMS       = 8;
    localparam int SEGMENTS        = MAX_BREAKPOINTS + 1;

    // Field and register widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int BP_W   = 3;
    localparam int SEG_W  = 4;
    localparam int TERM_W = 3;
    localparam int CNT_W  = 4;
    localparam int ADDR_W = 3;

    // Saturation limits in the width of a full product
    localparam logic signed [63:0] Q_MAX_64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN_64 = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // Request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_EVAL             = 2'd0,
        OP_WRITE_BREAKPOINT = 2'd1,
        OP_WRITE_COEF       = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic {
        REG_TERM_COUNT       = 1'b0,
        REG_BREAKPOINT_COUNT = 1'b1
    } reg_idx_t;

    // One request as it moves down the Horner chain
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [SEG_W-1:0]         seg;
        logic [TERM_W-1:0]        term;
        logic signed [DATA_W-1:0] acc;
        logic                     ovf;
    } item_t;

endpackage

// ===== src/ppe_horner_step.sv =====
// One Horner step: multiply stage, then shift, saturate and add stage.
// Holds the coefficient bank of its own term. Depends on ppe_pkg.
module ppe_horner_step #(
    parameter int TERM_INDEX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic [ppe_pkg::CNT_W-1:0]  nt,
    input  logic                       valid_in,
    input  ppe_pkg::item_t             item_in,
    output logic                       valid_out,
    output ppe_pkg::item_t             item_out
);

    localparam int CNT_W  = ppe_pkg::CNT_W;
    localparam int TERM_W = ppe_pkg::TERM_W;
    localparam int SEG_W  = ppe_pkg::SEG_W;
    localparam logic [TERM_W-1:0] TERM_CODE = TERM_W'(TERM_INDEX);
    localparam logic [CNT_W-1:0]  TERM_CNT  = CNT_W'(TERM_INDEX);
    localparam logic [SEG_W-1:0]  SEG_LIMIT = SEG_W'(ppe_pkg::SEGMENTS);

    // Coefficient bank of this term, one entry per segment
    logic signed [ppe_pkg::DATA_W-1:0] coef_mem [ppe_pkg::SEGMENTS];

    logic                              p_valid_reg;
    ppe_pkg::item_t                    p_item_reg;
    logic signed [63:0]                p_prod_reg;
    logic signed [ppe_pkg::DATA_W-1:0] p_coef_reg;
    logic signed [63:0]                p_prod_next;

    logic                              a_valid_reg;
    ppe_pkg::item_t                    a_item_reg;
    ppe_pkg::item_t                    a_item_next;

    logic                              coef_wr;

    // Multiply the running sum by x
    assign p_prod_next = item_in.acc * item_in.value;

    // Write the bank when a coefficient request for this term passes
    assign coef_wr = valid_in && adv
                     && (item_in.op == ppe_pkg::OP_WRITE_COEF)
                     && (item_in.term == TERM_CODE)
                     && (item_in.seg < SEG_LIMIT);

    // Bank write and registered read
    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            coef_mem[item_in.seg] <= item_in.value;
        end
        if (adv && (item_in.seg < SEG_LIMIT))
        begin
            p_coef_reg <= coef_mem[item_in.seg];
        end
    end

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_item_reg <= item_in;
            p_prod_reg <= p_prod_next;
        end
    end

    // Shift, saturate the product, add the coefficient, saturate the sum
    always_comb
    begin
        logic signed [63:0]                shifted;
        logic signed [ppe_pkg::DATA_W-1:0] prod32;
        logic signed [ppe_pkg::DATA_W-1:0] coef_eff;
        logic signed [ppe_pkg::DATA_W:0]   sum;
        logic                              ovf;

        a_item_next = p_item_reg;
        ovf         = p_item_reg.ovf;
        shifted     = p_prod_reg >>> 16;
        if (shifted > ppe_pkg::Q_MAX_64)
        begin
            prod32 = ppe_pkg::Q_MAX;
            ovf    = 1'b1;
        end
        else if (shifted < ppe_pkg::Q_MIN_64)
        begin
            prod32 = ppe_pkg::Q_MIN;
            ovf    = 1'b1;
        end
        else
        begin
            prod32 = shifted[ppe_pkg::DATA_W-1:0];
        end

        // Terms at or above the term count add nothing
        coef_eff = (TERM_CNT < nt) ? p_coef_reg : '0;
        sum = {prod32[ppe_pkg::DATA_W-1], prod32} + {coef_eff[ppe_pkg::DATA_W-1], coef_eff};
        if (sum[ppe_pkg::DATA_W] != sum[ppe_pkg::DATA_W-1])
        begin
            a_item_next.acc = sum[ppe_pkg::DATA_W] ? ppe_pkg::Q_MIN : ppe_pkg::Q_MAX;
            ovf             = 1'b1;
        end
        else
        begin
            a_item_next.acc = sum[ppe_pkg::DATA_W-1:0];
        end
        a_item_next.ovf = ovf;
    end

    // Add stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= a_item_next;
        end
    end

    assign valid_out = a_valid_reg;
    assign item_out  = a_item_reg;

    // Leading terms beyond the term count keep the sum at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && (a_item_reg.op == ppe_pkg::OP_EVAL) && (TERM_CNT >= nt))
        |-> (a_item_reg.acc == '0) && !a_item_reg.ovf)
        else $error("sum not zero above term count");

    // Once raised, the overflow flag survives the step
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && p_valid_reg && (p_item_reg.op == ppe_pkg::OP_EVAL) && p_item_reg.ovf)
        |=> a_item_reg.ovf)
        else $error("overflow flag lost");

    // A stalled stage holds its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && a_valid_reg)
        |=> a_valid_reg && $stable(a_item_reg.value) && $stable(a_item_reg.seg))
        else $error("request moved during stall");

endmodule

// ===== src/piecewise_polynomial_eval.sv =====
// Top level of the piecewise polynomial evaluator: input stage, segment search,
// Horner chain and configuration port. Depends on ppe_pkg and ppe_horner_step.
//
// Usage:
//   Requests enter on in_valid/in_ready with op, operand_value and the slots.
//   op OP_EVAL evaluates the curve at operand_value and gives one result on
//   out_valid/out_ready (curve_value, segment_used, overflow). Breakpoint and
//   coefficient writes, and the unused opcode, give no result; they travel
//   down the pipeline in order and update each store as they pass the stage
//   that reads it, so every request sees exactly the writes sent before it.
//   Pipeline: one input stage, one segment search stage, then a multiply stage
//   and an add stage for each of the MAX_TERMS Horner steps.
//   Throughput: one request per cycle while no result waits on a low out_ready.
//   Stall: while a result waits and out_ready is low the whole pipeline holds
//   and in_ready is low; nothing is lost or repeated.
//   Reset: term_count and breakpoint_count clear to zero and the pipeline
//   empties; both stores are undefined until written.
//   Configuration: APB writes to term_count (0x0) and breakpoint_count (0x4);
//   the user must write them only while no request is in flight (not enforced).
module piecewise_polynomial_eval (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ppe_pkg::OP_W-1:0]           op,
    input  logic signed [ppe_pkg::DATA_W-1:0]  operand_value,
    input  logic [ppe_pkg::BP_W-1:0]           breakpoint_slot,
    input  logic [ppe_pkg::SEG_W-1:0]          segment_slot,
    input  logic [ppe_pkg::TERM_W-1:0]         term_slot,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ppe_pkg::DATA_W-1:0]  curve_value,
    output logic [ppe_pkg::SEG_W-1:0]          segment_used,
    output logic                               overflow,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppe_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int CNT_W  = ppe_pkg::CNT_W;
    localparam int SEG_W  = ppe_pkg::SEG_W;
    localparam int NTERMS = ppe_pkg::MAX_TERMS;
    localparam int NBP    = ppe_pkg::MAX_BREAKPOINTS;
    localparam logic [CNT_W-1:0] MAX_BP_CNT   = CNT_W'(NBP);
    localparam logic [CNT_W-1:0] MAX_TERM_CNT = CNT_W'(NTERMS);

    logic                      adv;
    logic                      cfg_wr;
    ppe_pkg::reg_idx_t         cfg_idx;

    logic [CNT_W-1:0]          term_count_reg;
    logic [CNT_W-1:0]          breakpoint_count_reg;
    logic [CNT_W-1:0]          nt;
    logic [CNT_W-1:0]          nb;

    logic signed [ppe_pkg::DATA_W-1:0] bp_reg [NBP];

    logic                              s0_valid_reg;
    logic [ppe_pkg::OP_W-1:0]          s0_op_reg;
    logic signed [ppe_pkg::DATA_W-1:0] s0_value_reg;
    logic [ppe_pkg::BP_W-1:0]          s0_bslot_reg;
    logic [SEG_W-1:0]                  s0_seg_reg;
    logic [ppe_pkg::TERM_W-1:0]        s0_term_reg;

    logic                      s1_valid_reg;
    ppe_pkg::item_t            s1_item_reg;
    ppe_pkg::item_t            s1_item_next;
    logic [SEG_W-1:0]          seg_found;

    logic [NTERMS:0]           chain_valid;
    ppe_pkg::item_t            chain_item [NTERMS+1];

    // Hold everything while a result waits
    assign adv      = !(out_valid && !out_ready);
    assign in_ready = adv;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_idx = ppe_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg       <= '0;
            breakpoint_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                ppe_pkg::REG_TERM_COUNT:       term_count_reg       <= pwdata[CNT_W-1:0];
                ppe_pkg::REG_BREAKPOINT_COUNT: breakpoint_count_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            ppe_pkg::REG_TERM_COUNT:       prdata = {{(32-CNT_W){1'b0}}, term_count_reg};
            ppe_pkg::REG_BREAKPOINT_COUNT: prdata = {{(32-CNT_W){1'b0}}, breakpoint_count_reg};
            default:                       prdata = '0;
        endcase
    end

    // Clamp the counts to the store sizes
    assign nt = (term_count_reg > MAX_TERM_CNT) ? MAX_TERM_CNT : term_count_reg;
    assign nb = (breakpoint_count_reg > MAX_BP_CNT) ? MAX_BP_CNT : breakpoint_count_reg;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_op_reg    <= op;
            s0_value_reg <= operand_value;
            s0_bslot_reg <= breakpoint_slot;
            s0_seg_reg   <= segment_slot;
            s0_term_reg  <= term_slot;
        end
    end

    // Breakpoint store, written as the request leaves the input stage
    always_ff @(posedge clk)
    begin
        if (adv && s0_valid_reg && (s0_op_reg == ppe_pkg::OP_WRITE_BREAKPOINT))
        begin
            bp_reg[s0_bslot_reg] <= s0_value_reg;
        end
    end

    // Find the first breakpoint in use above x; fall back to the last segment
    always_comb
    begin
        seg_found = nb;
        for (int k = NBP - 1; k >= 0; k--)
        begin
            if ((CNT_W'(k) < nb) && (s0_value_reg < bp_reg[k]))
            begin
                seg_found = SEG_W'(k);
            end
        end
    end

    always_comb
    begin
        s1_item_next.op    = s0_op_reg;
        s1_item_next.value = s0_value_reg;
        s1_item_next.seg   = (s0_op_reg == ppe_pkg::OP_EVAL) ? seg_found : s0_seg_reg;
        s1_item_next.term  = s0_term_reg;
        s1_item_next.acc   = '0;
        s1_item_next.ovf   = 1'b0;
    end

    // Search stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    // Horner chain, highest term first
    assign chain_valid[0] = s1_valid_reg;
    assign chain_item[0]  = s1_item_reg;

    for (genvar j = 0; j < NTERMS; j++)
    begin : g_step
        ppe_horner_step #(
            .TERM_INDEX (NTERMS - 1 - j)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .nt        (nt),
            .valid_in  (chain_valid[j]),
            .item_in   (chain_item[j]),
            .valid_out (chain_valid[j+1]),
            .item_out  (chain_item[j+1])
        );
    end

    // Present only evaluate results
    assign out_valid    = chain_valid[NTERMS] && (chain_item[NTERMS].op == ppe_pkg::OP_EVAL);
    assign curve_value  = chain_item[NTERMS].acc;
    assign segment_used = chain_item[NTERMS].seg;
    assign overflow     = chain_item[NTERMS].ovf;

    // A waiting result blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request taken while result stalled");

    // The segment never exceeds the breakpoints in use
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (segment_used <= nb))
        else $error("segment beyond breakpoint count");

    // No terms gives a clean zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (nt == '0)) |-> ((curve_value == '0) && !overflow))
        else $error("non-zero result with no terms");

endmodule

// ===== dv/piecewise_polynomial_eval_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for piecewise_polynomial_eval: directed table, then randomised
// breakpoint/coefficient writes and evaluations checked against a Q16.16 Horner predictor.
// Depends on ppe_pkg and the piecewise_polynomial_eval RTL.
module piecewise_polynomial_eval_tb;

    localparam int DATA_W          = ppe_pkg::DATA_W;
    localparam int OP_W            = ppe_pkg::OP_W;
    localparam int BP_W            = ppe_pkg::BP_W;
    localparam int SEG_W           = ppe_pkg::SEG_W;
    localparam int TERM_W          = ppe_pkg::TERM_W;
    localparam int CNT_W           = ppe_pkg::CNT_W;
    localparam int ADDR_W          = ppe_pkg::ADDR_W;
    localparam int MAX_BREAKPOINTS = ppe_pkg::MAX_BREAKPOINTS;
    localparam int MAX_TERMS       = ppe_pkg::MAX_TERMS;
    localparam int SEGMENTS        = ppe_pkg::SEGMENTS;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES    = 2 * MAX_TERMS + 5;
    localparam int PRESSURE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_REQUESTS  = 65;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [SEG_W-1:0]         seg;
        logic                     ovf;
    } curve_result_t;

    typedef struct packed {
        bit                       is_setting;
        ppe_pkg::reg_idx_t        reg_sel;
        logic [CNT_W-1:0]         setting;
        logic [OP_W-1:0]          req_op;
        logic signed [DATA_W-1:0] value;
        logic [BP_W-1:0]          bslot;
        logic [SEG_W-1:0]         sslot;
        logic [TERM_W-1:0]        tslot;
        bit                       typed;
        curve_result_t            want;
    } directed_step_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          op = ppe_pkg::OP_EVAL;
    logic signed [DATA_W-1:0] operand_value = '0;
    logic [BP_W-1:0]          breakpoint_slot = '0;
    logic [SEG_W-1:0]         segment_slot = '0;
    logic [TERM_W-1:0]        term_slot = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] curve_value;
    logic [SEG_W-1:0]         segment_used;
    logic                     overflow;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    // Shadow copy of the block's stores and registers
    logic signed [DATA_W-1:0] shadow_bp [MAX_BREAKPOINTS];
    logic signed [DATA_W-1:0] shadow_coef [SEGMENTS][MAX_TERMS];
    logic [CNT_W-1:0]         shadow_terms = '0;
    logic [CNT_W-1:0]         shadow_bps = '0;

    curve_result_t  pending_curves [$];
    directed_step_t directed_steps [$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  overflow_results = 0;
    int  evals_sent = 0;
    int  writes_sent = 0;
    int  ignored_sent = 0;
    int  settings_applied = 0;
    bit  gaps_on = 1'b1;
    bit  pressure_done = 1'b0;
    int  phase_terms [NUM_PHASES];
    int  phase_bps [NUM_PHASES];

    piecewise_polynomial_eval dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .operand_value   (operand_value),
        .breakpoint_slot (breakpoint_slot),
        .segment_slot    (segment_slot),
        .term_slot       (term_slot),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .curve_value     (curve_value),
        .segment_used    (segment_used),
        .overflow        (overflow),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 clk = ~clk;

    // Clamp to the signed 32-bit range
    function automatic longint clamp_q(input longint v);
        if (v > ppe_pkg::Q_MAX_64)
            return ppe_pkg::Q_MAX_64;
        if (v < ppe_pkg::Q_MIN_64)
            return ppe_pkg::Q_MIN_64;
        return v;
    endfunction

    // Segment search, then Horner's rule with floor products and saturation at every step
    function automatic curve_result_t curve_at(input logic signed [DATA_W-1:0] x);
        curve_result_t r;
        int            nb;
        int            nt;
        int            seg;
        bit            hit;
        bit            ovf;
        longint        acc;
        longint        prod;
        nb  = (shadow_bps > MAX_BREAKPOINTS) ? MAX_BREAKPOINTS : int'(shadow_bps);
        nt  = (shadow_terms > MAX_TERMS) ? MAX_TERMS : int'(shadow_terms);
        seg = nb;
        hit = 1'b0;
        for (int k = 0; k < nb; k++)
        begin
            if (!hit && x < shadow_bp[k])
            begin
                seg = k;
                hit = 1'b1;
            end
        end
        acc = 0;
        ovf = 1'b0;
        for (int k = nt - 1; k >= 0; k--)
        begin
            prod = (acc * longint'(x)) >>> 16;
            if (clamp_q(prod) != prod)
                ovf = 1'b1;
            prod = clamp_q(prod);
            acc  = prod + longint'(shadow_coef[seg][k]);
            if (clamp_q(acc) != acc)
                ovf = 1'b1;
            acc = clamp_q(acc);
        end
        r.value = acc[DATA_W-1:0];
        r.seg   = seg[SEG_W-1:0];
        r.ovf   = ovf;
        return r;
    endfunction

    // Evaluation point: near a breakpoint, small, anywhere, or an extreme
    function automatic logic signed [DATA_W-1:0] pick_x();
        int     r;
        longint v;
        r = $urandom_range(0, 99);
        if (r < 35)
            v = longint'(shadow_bp[$urandom_range(0, MAX_BREAKPOINTS - 1)])
                + longint'(int'($urandom_range(0, 4)) - 2);
        else if (r < 65)
            v = longint'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        else if (r < 85)
            v = longint'(int'($urandom));
        else
        begin
            case ($urandom_range(0, 4))
                0: v = ppe_pkg::Q_MAX_64;
                1: v = ppe_pkg::Q_MIN_64;
                2: v = 0;
                3: v = -1;
                default: v = 1;
            endcase
        end
        v = clamp_q(v);
        return v[DATA_W-1:0];
    endfunction

    // Coefficient: a few units, a fraction, anything, or an extreme
    function automatic logic signed [DATA_W-1:0] pick_coef();
        int     r;
        longint v;
        r = $urandom_range(0, 99);
        if (r < 40)
            v = longint'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        else if (r < 65)
            v = longint'(int'($urandom_range(0, 1 << 13)) - (1 << 12));
        else if (r < 85)
            v = longint'(int'($urandom));
        else
        begin
            case ($urandom_range(0, 4))
                0: v = ppe_pkg::Q_MAX_64;
                1: v = ppe_pkg::Q_MIN_64;
                2: v = 0;
                3: v = 65536;
                default: v = -65536;
            endcase
        end
        return v[DATA_W-1:0];
    endfunction

    // Directed table builders
    function automatic void add_request(input logic [OP_W-1:0] o,
                                        input logic signed [DATA_W-1:0] v,
                                        input logic [BP_W-1:0] b,
                                        input logic [SEG_W-1:0] s,
                                        input logic [TERM_W-1:0] t);
        directed_step_t step;
        step        = '0;
        step.req_op = o;
        step.value  = v;
        step.bslot  = b;
        step.sslot  = s;
        step.tslot  = t;
        directed_steps.push_back(step);
    endfunction

    function automatic void add_checked_eval(input logic signed [DATA_W-1:0] v,
                                             input logic signed [DATA_W-1:0] want_value,
                                             input logic [SEG_W-1:0] want_seg,
                                             input logic want_ovf);
        directed_step_t step;
        step            = '0;
        step.req_op     = ppe_pkg::OP_EVAL;
        step.value      = v;
        step.typed      = 1'b1;
        step.want.value = want_value;
        step.want.seg   = want_seg;
        step.want.ovf   = want_ovf;
        directed_steps.push_back(step);
    endfunction

    function automatic void add_setting(input ppe_pkg::reg_idx_t idx,
                                        input logic [CNT_W-1:0] v);
        directed_step_t step;
        step            = '0;
        step.is_setting = 1'b1;
        step.reg_sel    = idx;
        step.setting    = v;
        directed_steps.push_back(step);
    endfunction

    // Offer one request (after a random gap while gaps_on is set), hold it until accepted, then record it
    task automatic offer_request(input logic [OP_W-1:0] req_op,
                                 input logic signed [DATA_W-1:0] req_value,
                                 input logic [BP_W-1:0] bslot,
                                 input logic [SEG_W-1:0] sslot,
                                 input logic [TERM_W-1:0] tslot,
                                 input bit has_typed,
                                 input curve_result_t typed_result);
        int r;
        int gap;
        bit took;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        op              <= req_op;
        operand_value   <= req_value;
        breakpoint_slot <= bslot;
        segment_slot    <= sslot;
        term_slot       <= tslot;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);

        // Apply the accepted request to the shadow state
        case (req_op)
            ppe_pkg::OP_EVAL:
            begin
                pending_curves.push_back(has_typed ? typed_result : curve_at(req_value));
                evals_sent++;
            end
            ppe_pkg::OP_WRITE_BREAKPOINT:
            begin
                shadow_bp[bslot] = req_value;
                writes_sent++;
            end
            ppe_pkg::OP_WRITE_COEF:
            begin
                if (sslot < SEGMENTS)
                begin
                    shadow_coef[sslot][tslot] = req_value;
                    writes_sent++;
                end
                else
                    ignored_sent++;
            end
            default: ignored_sent++;
        endcase
    endtask

    // Mostly evaluations; writes keep breakpoints ascending, with some noise mixed in
    task automatic random_request();
        int                       r;
        int                       k;
        longint                   lo;
        longint                   hi;
        longint                   pick;
        logic [OP_W-1:0]          rop;
        logic signed [DATA_W-1:0] val;
        logic [BP_W-1:0]          bs;
        logic [SEG_W-1:0]         ss;
        logic [TERM_W-1:0]        ts;
        r   = $urandom_range(0, 99);
        bs  = BP_W'($urandom);
        ss  = SEG_W'($urandom_range(0, SEGMENTS - 1));
        ts  = TERM_W'($urandom);
        val = pick_x();
        k   = int'(bs);
        if (r < 70)
            rop = ppe_pkg::OP_EVAL;
        else if (r < 80)
        begin
            rop = ppe_pkg::OP_WRITE_COEF;
            val = pick_coef();
        end
        else if (r < 86)
        begin
            rop = ppe_pkg::OP_WRITE_BREAKPOINT;
            lo  = (k == 0) ? longint'(shadow_bp[0]) - 262144 : longint'(shadow_bp[k - 1]) + 1;
            hi  = (k == MAX_BREAKPOINTS - 1) ? longint'(shadow_bp[k]) + 262144
                                             : longint'(shadow_bp[k + 1]) - 1;
            lo  = clamp_q(lo);
            hi  = clamp_q(hi);
            if (hi >= lo && hi - lo < 64'd4294967295)
            begin
                pick = lo + longint'($urandom_range(0, 32'(hi - lo)));
                val  = pick[DATA_W-1:0];
            end
            else
                val = $urandom;
        end
        else if (r < 90)
        begin
            rop = ppe_pkg::OP_WRITE_BREAKPOINT;
            val = $urandom;
        end
        else if (r < 95)
        begin
            rop = ppe_pkg::OP_WRITE_COEF;
            ss  = SEG_W'($urandom_range(SEGMENTS, 15));
            val = $urandom;
        end
        else
            rop = OP_UNUSED;
        offer_request(rop, val, bs, ss, ts, 1'b0, '0);
    endtask

    // Drop valid and let every request in flight leave the pipeline
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_curves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register over APB, then read it back
    task automatic set_register(input ppe_pkg::reg_idx_t idx, input logic [CNT_W-1:0] value);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(32 - CNT_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got[CNT_W-1:0] !== value)
        begin
            $error("register %s: expected %0d, got %0d", idx.name(), value, got[CNT_W-1:0]);
            mismatches++;
        end
        if (idx == ppe_pkg::REG_TERM_COUNT)
            shadow_terms = value;
        else
            shadow_bps = value;
        settings_applied++;
    endtask

    // Receiver: random back-pressure, with one long hold to fill the pipeline
    initial
    begin : result_sink
        int r;
        int len;
        bit level;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (!pressure_done && results_seen >= 150 && in_valid)
            begin
                level         = 1'b0;
                len           = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            else if (r < 55)
            begin
                level = 1'b1;
                len   = $urandom_range(1, 24);
            end
            else if (r < 90)
            begin
                level = 1'b0;
                len   = $urandom_range(1, 3);
            end
            else if (r < 97)
            begin
                level = 1'b1;
                len   = $urandom_range(40, 80);
            end
            else
            begin
                level = 1'b0;
                len   = $urandom_range(20, 60);
            end
            out_ready <= level;
            repeat (len) @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(negedge clk)
    begin : check_results
        curve_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_curves.size() == 0)
            begin
                $error("result with no request waiting: curve_value %h segment_used %0d",
                       curve_value, segment_used);
                mismatches++;
            end
            else
            begin
                want = pending_curves.pop_front();
                if (curve_value !== want.value)
                begin
                    $error("curve_value: expected %h, got %h", want.value, curve_value);
                    mismatches++;
                end
                if (segment_used !== want.seg)
                begin
                    $error("segment_used: expected %0d, got %0d", want.seg, segment_used);
                    mismatches++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, overflow);
                    mismatches++;
                end
                if (want.ovf)
                    overflow_results++;
            end
        end
    end

    // Abort when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        longint edge_pos;

        // Reset settings: nothing is read, every evaluation gives zero in segment 0
        add_checked_eval(32'sd0, 32'sd0, 4'd0, 1'b0);
        add_checked_eval(ppe_pkg::Q_MAX, 32'sd0, 4'd0, 1'b0);
        add_checked_eval(ppe_pkg::Q_MIN, 32'sd0, 4'd0, 1'b0);
        add_request(OP_UNUSED, 32'sh1234_5678, 3'd5, 4'd3, 3'd2);
        add_request(ppe_pkg::OP_WRITE_COEF, 32'sh7654_3210, 3'd0, 4'd15, 3'd7);
        // Constant curve at full scale
        add_setting(ppe_pkg::REG_TERM_COUNT, 4'd1);
        add_request(ppe_pkg::OP_WRITE_COEF, ppe_pkg::Q_MAX, 3'd0, 4'd0, 3'd0);
        add_checked_eval(32'sd12345, ppe_pkg::Q_MAX, 4'd0, 1'b0);
        // Linear term at full scale: saturating products and sums, floor on negatives
        add_setting(ppe_pkg::REG_TERM_COUNT, 4'd2);
        add_request(ppe_pkg::OP_WRITE_COEF, ppe_pkg::Q_MAX, 3'd0, 4'd0, 3'd1);
        add_checked_eval(ppe_pkg::Q_MAX, ppe_pkg::Q_MAX, 4'd0, 1'b1);
        add_checked_eval(ppe_pkg::Q_MIN, -32'sd1, 4'd0, 1'b1);
        add_request(ppe_pkg::OP_EVAL, -32'sd1, 3'd7, 4'd8, 3'd7);
        add_request(ppe_pkg::OP_EVAL, 32'sd1, 3'd0, 4'd0, 3'd0);
        add_request(ppe_pkg::OP_WRITE_COEF, 32'sh0001_0000, 3'd7, 4'd0, 3'd1);
        add_request(ppe_pkg::OP_WRITE_COEF, ppe_pkg::Q_MIN, 3'd0, 4'd0, 3'd0);
        add_checked_eval(-32'sd1, ppe_pkg::Q_MIN, 4'd0, 1'b1);
        // One breakpoint at zero: x equal to it falls in the upper segment
        add_setting(ppe_pkg::REG_BREAKPOINT_COUNT, 4'd1);
        add_request(ppe_pkg::OP_WRITE_BREAKPOINT, 32'sd0, 3'd0, 4'd0, 3'd0);
        add_request(ppe_pkg::OP_WRITE_COEF, 32'sh0002_0000, 3'd0, 4'd1, 3'd0);
        add_request(ppe_pkg::OP_WRITE_COEF, 32'sd0, 3'd0, 4'd1, 3'd1);
        add_checked_eval(32'sd0, 32'sh0002_0000, 4'd1, 1'b0);
        add_checked_eval(ppe_pkg::Q_MAX, 32'sh0002_0000, 4'd1, 1'b0);
        add_request(ppe_pkg::OP_EVAL, -32'sd1, 3'd3, 4'd5, 3'd4);

        phase_terms = '{8, 15, 1, 4, 0, 8, 6, 3};
        phase_bps   = '{8, 15, 0, 3, 8, 1, 5, 2};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_setting)
            begin
                wait_idle();
                set_register(directed_steps[i].reg_sel, directed_steps[i].setting);
            end
            else
                offer_request(directed_steps[i].req_op, directed_steps[i].value,
                              directed_steps[i].bslot, directed_steps[i].sslot,
                              directed_steps[i].tslot, directed_steps[i].typed,
                              directed_steps[i].want);
        end

        // Fill both stores: ascending breakpoints, then every coefficient
        edge_pos = longint'(int'($urandom_range(0, 1 << 16)) - (1 << 19));
        for (int k = 0; k < MAX_BREAKPOINTS; k++)
        begin
            offer_request(ppe_pkg::OP_WRITE_BREAKPOINT, edge_pos[DATA_W-1:0], BP_W'(k),
                          SEG_W'($urandom), TERM_W'($urandom), 1'b0, '0);
            edge_pos += longint'(1 + int'($urandom_range(0, 1 << 17)));
        end
        for (int s = 0; s < SEGMENTS; s++)
        begin
            for (int t = 0; t < MAX_TERMS; t++)
            begin
                offer_request(ppe_pkg::OP_WRITE_COEF, pick_coef(), BP_W'($urandom),
                              SEG_W'(s), TERM_W'(t), 1'b0, '0);
                if ($urandom_range(0, 99) < 30)
                    random_request();
            end
        end

        // Random phases over a spread of register settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            set_register(ppe_pkg::REG_TERM_COUNT, CNT_W'(phase_terms[p]));
            set_register(ppe_pkg::REG_BREAKPOINT_COUNT, CNT_W'(phase_bps[p]));
            gaps_on = (p % 3 != 1);
            repeat (PHASE_REQUESTS) random_request();
        end

        wait_idle();
        $display("Sent %0d evaluations, %0d store writes and %0d ignored requests",
                 evals_sent, writes_sent, ignored_sent);
        $display("Checked %0d results (%0d saturated) over %0d register writes",
                 results_seen, overflow_results, settings_applied);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
